FILE: rtl/crd_pkg.sv
// Shared constants, the named reference table and its helper for the
// character reference decoder. No dependencies.
package crd_pkg;

  localparam int MAX_NAME_LEN_DEF = 6;
  localparam int CMDQ_DEPTH_DEF   = 4;

  // Longest name in the table and the number of entries.
  localparam int NAME_TBL_LEN = 6;
  localparam int NUM_ENT      = 43;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UX   = 8'h58;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] CP_SAT  = 21'h110000;
  localparam logic [20:0] CP_LIM1 = 21'h000080;
  localparam logic [20:0] CP_LIM2 = 21'h000800;
  localparam logic [20:0] CP_LIM3 = 21'h010000;

  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_MASK  = 8'h3F;

  localparam logic [23:0] REPL_CHAR = 24'hEFBFBD;

  // Names are right-justified: the last character sits in the low byte.
  // UTF-8 bytes are left-justified: the first byte sits in bits 23:16.
  typedef struct packed {
    logic [47:0] nm;
    logic [2:0]  nlen;
    logic [23:0] utf;
    logic [1:0]  ulen;
  } ent_t;

  localparam ent_t ENT_TABLE [NUM_ENT] = '{
    '{"amp",    3'd3, 24'h260000, 2'd1}, '{"lt",     3'd2, 24'h3C0000, 2'd1},
    '{"gt",     3'd2, 24'h3E0000, 2'd1}, '{"quot",   3'd4, 24'h220000, 2'd1},
    '{"apos",   3'd4, 24'h270000, 2'd1}, '{"nbsp",   3'd4, 24'hC2A000, 2'd2},
    '{"copy",   3'd4, 24'hC2A900, 2'd2}, '{"reg",    3'd3, 24'hC2AE00, 2'd2},
    '{"trade",  3'd5, 24'hE284A2, 2'd3}, '{"mdash",  3'd5, 24'hE28094, 2'd3},
    '{"ndash",  3'd5, 24'hE28093, 2'd3}, '{"laquo",  3'd5, 24'hC2AB00, 2'd2},
    '{"raquo",  3'd5, 24'hC2BB00, 2'd2}, '{"ldquo",  3'd5, 24'hE2809C, 2'd3},
    '{"rdquo",  3'd5, 24'hE2809D, 2'd3}, '{"lsquo",  3'd5, 24'hE28098, 2'd3},
    '{"rsquo",  3'd5, 24'hE28099, 2'd3}, '{"hellip", 3'd6, 24'hE280A6, 2'd3},
    '{"bull",   3'd4, 24'hE280A2, 2'd3}, '{"deg",    3'd3, 24'hC2B000, 2'd2},
    '{"plusmn", 3'd6, 24'hC2B100, 2'd2}, '{"times",  3'd5, 24'hC39700, 2'd2},
    '{"divide", 3'd6, 24'hC3B700, 2'd2}, '{"euro",   3'd4, 24'hE282AC, 2'd3},
    '{"pound",  3'd5, 24'hC2A300, 2'd2}, '{"yen",    3'd3, 24'hC2A500, 2'd2},
    '{"cent",   3'd4, 24'hC2A200, 2'd2}, '{"sect",   3'd4, 24'hC2A700, 2'd2},
    '{"para",   3'd4, 24'hC2B600, 2'd2}, '{"middot", 3'd6, 24'hC2B700, 2'd2},
    '{"frac12", 3'd6, 24'hC2BD00, 2'd2}, '{"frac14", 3'd6, 24'hC2BC00, 2'd2},
    '{"frac34", 3'd6, 24'hC2BE00, 2'd2}, '{"iexcl",  3'd5, 24'hC2A100, 2'd2},
    '{"iquest", 3'd6, 24'hC2BF00, 2'd2}, '{"larr",   3'd4, 24'hE28690, 2'd3},
    '{"rarr",   3'd4, 24'hE28692, 2'd3}, '{"uarr",   3'd4, 24'hE28691, 2'd3},
    '{"darr",   3'd4, 24'hE28693, 2'd3}, '{"hearts", 3'd6, 24'hE299A5, 2'd3},
    '{"diams",  3'd5, 24'hE299A6, 2'd3}, '{"clubs",  3'd5, 24'hE299A3, 2'd3},
    '{"spades", 3'd6, 24'hE299A0, 2'd3}
  };

  // Character j (from the start) of table entry k.
  function automatic logic [7:0] ent_char(input int k, input int j);
    logic [47:0] s;
    s = ENT_TABLE[k].nm << (8 * (NAME_TBL_LEN - int'(ENT_TABLE[k].nlen)));
    return s[47 - 8 * j -: 8];
  endfunction

endpackage

FILE: rtl/crd_front.sv
// Front end of the character reference decoder: reference state machine,
// name buffer, numeric accumulator and lookup. Builds at most one command
// per word. Depends on crd_pkg.
module crd_front import crd_pkg::*; #(
  parameter int  MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  localparam int CMD_BYTES    = MAX_NAME_LEN + 2,
  localparam int CNTW         = $clog2(CMD_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic [7:0]                   in_byte,
  input  logic                         in_end_of_input,
  output logic                         enq,
  output logic [CMD_BYTES-1:0][7:0]    cmd_bytes,
  output logic [CNTW-1:0]              cmd_n
);

  localparam int NLW = $clog2(MAX_NAME_LEN + 1);
  localparam int IW  = $clog2(MAX_NAME_LEN);

  typedef enum logic [6:0] {
    M_TEXT = 7'b0000001,
    M_AMP  = 7'b0000010,
    M_HASH = 7'b0000100,
    M_HEXS = 7'b0001000,
    M_DEC  = 7'b0010000,
    M_HEX  = 7'b0100000,
    M_NAME = 7'b1000000
  } mode_t;

  typedef enum logic [2:0] {
    PK_NONE, PK_AMP, PK_HASH, PK_HEXS, PK_ENC, PK_NAMED, PK_REPLAY
  } pre_t;

  mode_t            mode_r, mode_nxt;
  logic [7:0]       name_buf_r [MAX_NAME_LEN];
  logic [NLW-1:0]   len_r, len_nxt;
  logic [20:0]      cp_r, cp_nxt;
  logic             ux_r, ux_nxt;

  logic             is_dec, is_hex, is_alnum, is_semi;
  logic [3:0]       dv;
  logic [25:0]      acc_v;
  logic [20:0]      acc_sat;
  logic             hit;
  logic [23:0]      named;
  logic [1:0]       named_n;
  logic [31:0]      enc;
  logic [2:0]       enc_n;
  pre_t             pk;
  logic             do_txt, do_clr, tail;
  logic             buf_we;
  logic [IW-1:0]    buf_wa;
  logic [CMD_BYTES-1:0][7:0] pre;
  logic [CNTW-1:0]  pre_n;

  // Character classes of the incoming byte.
  always_comb begin
    is_dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_hex   = is_dec || ((in_byte >= 8'h61) && (in_byte <= 8'h66)) ||
               ((in_byte >= 8'h41) && (in_byte <= 8'h46));
    is_alnum = is_dec || ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
               ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
    is_semi  = (in_byte == CH_SEMI);
    dv       = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
  end

  // Next accumulator value; times ten is two shifted copies.
  always_comb begin
    if (mode_r == M_HEX) begin
      acc_v = {1'b0, cp_r, 4'b0} + 26'(dv);
    end else begin
      acc_v = {2'b0, cp_r, 3'b0} + {4'b0, cp_r, 1'b0} + 26'(dv);
    end
    acc_sat = (acc_v > 26'(CP_MAX)) ? CP_SAT : acc_v[20:0];
  end

  // Named lookup: each entry compares the buffered characters in parallel.
  always_comb begin
    logic eq;
    hit     = 1'b0;
    named   = '0;
    named_n = '0;
    for (int k = 0; k < NUM_ENT; k++) begin
      eq = (len_r == NLW'(ENT_TABLE[k].nlen));
      for (int j = 0; j < NAME_TBL_LEN; j++) begin
        if (j < int'(ENT_TABLE[k].nlen)) begin
          eq = eq & (name_buf_r[j] == ent_char(k, j));
        end
      end
      if (eq && !hit) begin
        hit     = 1'b1;
        named   = ENT_TABLE[k].utf;
        named_n = ENT_TABLE[k].ulen;
      end
    end
  end

  // UTF-8 encoding of the accumulated code point.
  always_comb begin
    enc   = '0;
    enc_n = 3'd3;
    if ((cp_r == '0) || (cp_r > CP_MAX)) begin
      enc = {REPL_CHAR, 8'h00};
    end else if (cp_r < CP_LIM1) begin
      enc   = {1'b0, cp_r[6:0], 24'h0};
      enc_n = 3'd1;
    end else if (cp_r < CP_LIM2) begin
      enc   = {UTF_LEAD2 | {3'b0, cp_r[10:6]},
               UTF_CONT | ({2'b0, cp_r[5:0]} & UTF_MASK), 16'h0};
      enc_n = 3'd2;
    end else if (cp_r < CP_LIM3) begin
      enc   = {UTF_LEAD3 | {4'b0, cp_r[15:12]},
               UTF_CONT | {2'b0, cp_r[11:6]},
               UTF_CONT | {2'b0, cp_r[5:0]}, 8'h0};
    end else begin
      enc   = {UTF_LEAD4 | {5'b0, cp_r[20:18]},
               UTF_CONT | {2'b0, cp_r[17:12]},
               UTF_CONT | {2'b0, cp_r[11:6]},
               UTF_CONT | {2'b0, cp_r[5:0]}};
      enc_n = 3'd4;
    end
  end

  // Reference state machine.
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    cp_nxt   = cp_r;
    ux_nxt   = ux_r;
    pk       = PK_NONE;
    do_txt   = 1'b0;
    do_clr   = 1'b0;
    buf_we   = 1'b0;
    buf_wa   = '0;
    if (in_end_of_input) begin
      do_clr = 1'b1;
      unique case (mode_r) inside
        M_AMP:        pk = PK_AMP;
        M_HASH:       pk = PK_HASH;
        M_HEXS:       pk = PK_HEXS;
        M_DEC, M_HEX: pk = PK_ENC;
        M_NAME:       pk = hit ? PK_NAMED : PK_REPLAY;
        default:      pk = PK_NONE;
      endcase
    end else begin
      unique case (mode_r) inside
        M_AMP: begin
          if (in_byte == CH_HASH) begin
            mode_nxt = M_HASH;
          end else if (is_alnum) begin
            buf_we   = 1'b1;
            len_nxt  = NLW'(1);
            mode_nxt = M_NAME;
          end else begin
            pk     = PK_AMP;
            do_txt = 1'b1;
          end
        end
        M_HASH: begin
          if (is_dec) begin
            cp_nxt   = 21'(dv);
            mode_nxt = M_DEC;
          end else if ((in_byte == CH_LX) || (in_byte == CH_UX)) begin
            ux_nxt   = (in_byte == CH_UX);
            mode_nxt = M_HEXS;
          end else begin
            pk     = PK_HASH;
            do_txt = 1'b1;
          end
        end
        M_HEXS: begin
          if (is_hex) begin
            cp_nxt   = 21'(dv);
            mode_nxt = M_HEX;
          end else begin
            pk     = PK_HEXS;
            do_txt = 1'b1;
          end
        end
        M_DEC, M_HEX: begin
          if ((mode_r == M_HEX) ? is_hex : is_dec) begin
            cp_nxt = acc_sat;
          end else begin
            pk     = PK_ENC;
            do_clr = is_semi;
            do_txt = !is_semi;
          end
        end
        M_NAME: begin
          if (is_alnum) begin
            if (len_r < NLW'(MAX_NAME_LEN)) begin
              buf_we  = 1'b1;
              buf_wa  = len_r[IW-1:0];
              len_nxt = len_r + NLW'(1);
            end else begin
              pk     = PK_REPLAY;
              do_txt = 1'b1;
            end
          end else if (hit) begin
            pk     = PK_NAMED;
            do_clr = is_semi;
            do_txt = !is_semi;
          end else begin
            pk     = PK_REPLAY;
            do_txt = 1'b1;
          end
        end
        default: do_txt = 1'b1;
      endcase
    end
    tail = 1'b0;
    if (do_clr || do_txt) begin
      mode_nxt = M_TEXT;
      len_nxt  = '0;
      cp_nxt   = '0;
      ux_nxt   = 1'b0;
    end
    if (do_txt) begin
      if (in_byte == CH_AMP) begin
        mode_nxt = M_AMP;
      end else begin
        tail = 1'b1;
      end
    end
  end

  // Bytes that come before the optional pass-through byte.
  always_comb begin
    pre   = '0;
    pre_n = '0;
    unique case (pk)
      PK_AMP: begin
        pre[0] = CH_AMP;
        pre_n  = CNTW'(1);
      end
      PK_HASH: begin
        pre[0] = CH_AMP;
        pre[1] = CH_HASH;
        pre_n  = CNTW'(2);
      end
      PK_HEXS: begin
        pre[0] = CH_AMP;
        pre[1] = CH_HASH;
        pre[2] = ux_r ? CH_UX : CH_LX;
        pre_n  = CNTW'(3);
      end
      PK_ENC: begin
        pre[0] = enc[31:24];
        pre[1] = enc[23:16];
        pre[2] = enc[15:8];
        pre[3] = enc[7:0];
        pre_n  = CNTW'(enc_n);
      end
      PK_NAMED: begin
        pre[0] = named[23:16];
        pre[1] = named[15:8];
        pre[2] = named[7:0];
        pre_n  = CNTW'(named_n);
      end
      PK_REPLAY: begin
        pre[0] = CH_AMP;
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
          pre[i+1] = name_buf_r[i];
        end
        pre_n = CNTW'(len_r) + CNTW'(1);
      end
      default: pre_n = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CMD_BYTES; i++) begin
      cmd_bytes[i] = (CNTW'(i) < pre_n) ? pre[i] : in_byte;
    end
    cmd_n = pre_n + CNTW'(tail);
    enq   = acc && (cmd_n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_TEXT;
      len_r  <= '0;
      cp_r   <= '0;
      ux_r   <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      cp_r   <= cp_nxt;
      ux_r   <= ux_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && buf_we) begin
      name_buf_r[buf_wa] <= in_byte;
    end
  end

endmodule

FILE: rtl/crd_cmdq.sv
// Command queue between the front end and the byte expander of the
// character reference decoder. Depends on crd_pkg for its default depth.
module crd_cmdq import crd_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         enq,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         deq,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    rp_nxt  = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    cnt_nxt = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (enq) begin
        wp_r <= wp_nxt;
      end
      if (deq) begin
        rp_r <= rp_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: rtl/crd_back.sv
// Byte expander of the character reference decoder: holds one command and
// hands out its bytes one byte at a time. Depends on crd_pkg.
module crd_back import crd_pkg::*; #(
  parameter int  MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  localparam int CMD_BYTES    = MAX_NAME_LEN + 2,
  localparam int CNTW         = $clog2(CMD_BYTES + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [CMD_BYTES-1:0][7:0] q_bytes,
  input  logic [CNTW-1:0]           q_n,
  output logic                      q_deq,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [7:0]                out_byte,
  output logic                      out_last
);

  localparam int IXW = $clog2(CMD_BYTES);

  logic [CMD_BYTES-1:0][7:0] cur_bytes_r;
  logic [CNTW-1:0]           cur_n_r;
  logic [IXW-1:0]            idx_r;
  logic                      valid_r;
  logic                      fin, load;

  assign out_empty = !valid_r;
  assign out_byte  = cur_bytes_r[idx_r];
  assign out_last  = (CNTW'(idx_r) + CNTW'(1) == cur_n_r);

  // The next command is taken as the current one's final byte leaves.
  assign fin   = valid_r && out_pop && out_last;
  assign load  = (!valid_r || fin) && !q_empty;
  assign q_deq = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (fin) begin
      valid_r <= 1'b0;
    end else if (valid_r && out_pop) begin
      idx_r <= idx_r + IXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_bytes_r <= q_bytes;
      cur_n_r     <= q_n;
    end
  end

endmodule

FILE: rtl/char_reference_to_utf8_decoder.sv
// Top level of the character reference decoder: front end, command queue
// and byte expander. Depends on crd_pkg, crd_front, crd_cmdq and crd_back.
//
// Text bytes go in at one word per cycle; plain bytes come out unchanged and
// references beginning with '&' come out as UTF-8 (or are replayed as text
// when they fail). The front end classifies each input word combinationally
// and turns it into one command of up to MAX_NAME_LEN + 2 bytes, which
// waits in a queue of QUEUE_DEPTH commands. The expander hands out one
// result byte per cycle while out_pop is high; the first byte of a word
// reaches the output once its command has gone through the queue into the
// expander. Input stalls (in_full high) only when the command queue is full,
// so with out_pop held high a stream averaging at most one result byte per
// input word runs at one word per cycle. out_last marks the final byte that
// one input word produced; words that produce nothing leave no trace.
module char_reference_to_utf8_decoder import crd_pkg::*; #(
  parameter int MAX_NAME_LEN = MAX_NAME_LEN_DEF,
  parameter int QUEUE_DEPTH  = CMDQ_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  localparam int CMD_BYTES = MAX_NAME_LEN + 2;
  localparam int CNTW      = $clog2(CMD_BYTES + 1);
  localparam int QW        = CMD_BYTES * 8 + CNTW;

  logic                      acc;
  logic                      q_enq, q_full, q_deq, q_empty;
  logic [CMD_BYTES-1:0][7:0] cmd_bytes;
  logic [CNTW-1:0]           cmd_n;
  logic [QW-1:0]             q_rdata;
  logic [CMD_BYTES-1:0][7:0] q_head_bytes;
  logic [CNTW-1:0]           q_head_n;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  crd_front #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .acc             (acc),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .enq             (q_enq),
    .cmd_bytes       (cmd_bytes),
    .cmd_n           (cmd_n)
  );

  crd_cmdq #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .enq   (q_enq),
    .wdata ({cmd_n, cmd_bytes}),
    .full  (q_full),
    .deq   (q_deq),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_head_n     = q_rdata[QW-1 -: CNTW];
  assign q_head_bytes = q_rdata[CMD_BYTES*8-1:0];

  crd_back #(
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_bytes   (q_head_bytes),
    .q_n       (q_head_n),
    .q_deq     (q_deq),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // A command is only written when there is room for it.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_enq |-> !q_full)
    else $error("command written into a full queue");

  // Every queued command carries at least one byte and no more than fit.
  a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty |-> ((q_head_n != '0) && (q_head_n <= CNTW'(CMD_BYTES))))
    else $error("queued command has an impossible length");

  // Taking a byte that is not the last of its word leaves the rest waiting.
  a_word_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=> !out_empty)
    else $error("result word lost before its last byte");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the character reference decoder: a directed
// script, then randomised references and noise, checked against a predictor.
// Depends only on the top level char_reference_to_utf8_decoder.
`timescale 1ns / 100ps

module tb;

  typedef enum logic [2:0] {
    ST_TEXT, ST_AMP, ST_HASH, ST_HEXSTART, ST_DEC, ST_HEX, ST_NAME
  } ref_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  typedef struct {
    logic [7:0]  b;
    logic        eoi;
    int          n;
    logic [63:0] bytes;
  } script_row_t;

  localparam int PREDICT       = -1;
  localparam int NAME_MAX      = 6;
  localparam int ENT_COUNT     = 43;
  localparam int RANDOM_WORDS  = 390;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SIDE_IN       = 0;
  localparam int SIDE_OUT      = 1;

  localparam logic [7:0]  AMP_CH       = "&";
  localparam logic [7:0]  HASH_CH      = "#";
  localparam logic [7:0]  SEMI_CH      = ";";
  localparam logic [7:0]  LOWER_X_CH   = "x";
  localparam logic [7:0]  UPPER_X_CH   = "X";
  localparam logic [20:0] CP_TOP       = 21'h10FFFF;
  localparam logic [20:0] CP_SATURATED = 21'h110000;
  localparam logic [23:0] REPLACEMENT  = 24'hEFBFBD;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_LEAD4   = 8'hF0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;

  localparam int unsigned CP_CORNERS [8] = '{
    'h7F, 'h80, 'h7FF, 'h800, 'hFFFF, 'h10000, 'h10FFFF, 'h110000
  };

  localparam string ALNUM =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";

  // Named references; the UTF-8 bytes are left-justified and never zero.
  string ent_name [ENT_COUNT] = '{
    "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg", "trade", "mdash",
    "ndash", "laquo", "raquo", "ldquo", "rdquo", "lsquo", "rsquo", "hellip",
    "bull", "deg", "plusmn", "times", "divide", "euro", "pound", "yen", "cent",
    "sect", "para", "middot", "frac12", "frac14", "frac34", "iexcl", "iquest",
    "larr", "rarr", "uarr", "darr", "hearts", "diams", "clubs", "spades"
  };
  logic [23:0] ent_utf [ENT_COUNT] = '{
    24'h260000, 24'h3C0000, 24'h3E0000, 24'h220000, 24'h270000, 24'hC2A000,
    24'hC2A900, 24'hC2AE00, 24'hE284A2, 24'hE28094, 24'hE28093, 24'hC2AB00,
    24'hC2BB00, 24'hE2809C, 24'hE2809D, 24'hE28098, 24'hE28099, 24'hE280A6,
    24'hE280A2, 24'hC2B000, 24'hC2B100, 24'hC39700, 24'hC3B700, 24'hE282AC,
    24'hC2A300, 24'hC2A500, 24'hC2A200, 24'hC2A700, 24'hC2B600, 24'hC2B700,
    24'hC2BD00, 24'hC2BC00, 24'hC2BE00, 24'hC2A100, 24'hC2BF00, 24'hE28690,
    24'hE28692, 24'hE28691, 24'hE28693, 24'hE299A5, 24'hE299A6, 24'hE299A3,
    24'hE299A0
  };

  // Directed script: a typed expectation where it is obvious, else predicted.
  script_row_t script [29] = '{
    '{"A",   1'b0, 1, 64'h41_00_00_00_00_00_00_00},
    '{8'h00, 1'b0, 1, 64'h00_00_00_00_00_00_00_00},
    '{8'hFF, 1'b0, 1, 64'hFF_00_00_00_00_00_00_00},
    '{8'hA5, 1'b1, 0, 64'h0},
    '{"&",   1'b0, 0, 64'h0},
    '{"#",   1'b0, 0, 64'h0},
    '{"X",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"F",   1'b0, 0, 64'h0},
    '{"<",   1'b0, 4, 64'hEF_BF_BD_3C_00_00_00_00},
    '{"&",   1'b0, 0, 64'h0},
    '{"#",   1'b0, 0, 64'h0},
    '{"q",   1'b0, 3, 64'h26_23_71_00_00_00_00_00},
    '{"&",   1'b0, 0, 64'h0},
    '{"l",   1'b0, 0, 64'h0},
    '{"t",   1'b0, 0, 64'h0},
    '{8'h00, 1'b1, 1, 64'h3C_00_00_00_00_00_00_00},
    '{"&",   1'b0, 0, 64'h0},
    '{"z",   1'b0, 0, 64'h0},
    '{"z",   1'b0, 0, 64'h0},
    '{";",   1'b0, 4, 64'h26_7A_7A_3B_00_00_00_00},
    '{"&",   1'b0, PREDICT, 64'h0},
    '{"#",   1'b0, PREDICT, 64'h0},
    '{"9",   1'b0, PREDICT, 64'h0},
    '{8'h00, 1'b1, PREDICT, 64'h0}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_end_of_input;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_last;

  // Predictor state.
  ref_mode_t   rmode = ST_TEXT;
  logic [7:0]  nbuf [NAME_MAX] = '{default: 8'h00};
  int          nlen = 0;
  logic [20:0] cp = '0;
  bit          hex_upper = 1'b0;
  logic [7:0]  step_bytes [$];

  out_word_t   utf8_expected [$];
  out_word_t   oldest;
  bit          calm [2] = '{1'b0, 1'b0};

  int errors = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int ends_sent = 0;
  int bytes_seen = 0;
  int longest_step = 0;
  int n_plain = 0, n_named = 0, n_numeric = 0, n_free_name = 0, n_broken = 0;

  char_reference_to_utf8_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_byte         (in_byte),
    .in_end_of_input (in_end_of_input),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum(input logic [7:0] c);
    return is_dec(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (is_dec(c)) return int'(c) - "0";
    if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
    if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
    return -1;
  endfunction

  function automatic void emit(input logic [7:0] c);
    step_bytes = {step_bytes, c};
  endfunction

  function automatic void clear_ref();
    rmode = ST_TEXT;
    nlen = 0;
    cp = '0;
    hex_upper = 1'b0;
  endfunction

  function automatic void as_text(input logic [7:0] c);
    clear_ref();
    if (c == AMP_CH) rmode = ST_AMP;
    else emit(c);
  endfunction

  function automatic void replay_hex_start();
    emit(AMP_CH);
    emit(HASH_CH);
    emit(hex_upper ? UPPER_X_CH : LOWER_X_CH);
  endfunction

  function automatic void replay_name();
    emit(AMP_CH);
    for (int i = 0; i < nlen; i++) emit(nbuf[i]);
  endfunction

  function automatic void encode_cp();
    if (cp == 0 || cp > CP_TOP) begin
      emit(REPLACEMENT[23:16]);
      emit(REPLACEMENT[15:8]);
      emit(REPLACEMENT[7:0]);
    end else if (cp < 21'h80) begin
      emit(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit(UTF8_LEAD2 | {3'b0, cp[10:6]});
      emit(UTF8_CONT | {2'b0, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit(UTF8_LEAD3 | {4'b0, cp[15:12]});
      emit(UTF8_CONT | {2'b0, cp[11:6]});
      emit(UTF8_CONT | {2'b0, cp[5:0]});
    end else begin
      emit(UTF8_LEAD4 | {5'b0, cp[20:18]});
      emit(UTF8_CONT | {2'b0, cp[17:12]});
      emit(UTF8_CONT | {2'b0, cp[11:6]});
      emit(UTF8_CONT | {2'b0, cp[5:0]});
    end
  endfunction

  // Exact, case-sensitive match; emits the entity's bytes on a hit.
  function automatic bit lookup_name();
    bit hit;
    for (int k = 0; k < ENT_COUNT; k++) begin
      if (ent_name[k].len() != nlen) continue;
      hit = 1'b1;
      for (int j = 0; j < nlen; j++)
        if (ent_name[k].getc(j) != nbuf[j]) hit = 1'b0;
      if (hit) begin
        for (int j = 0; j < 3; j++)
          if (ent_utf[k][23 - 8*j -: 8] != 8'h00) emit(ent_utf[k][23 - 8*j -: 8]);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Works out the bytes that one accepted word produces into step_bytes.
  function automatic void decode_word(input logic [7:0] b, input logic eoi);
    int          hv;
    int unsigned acc;
    step_bytes.delete();
    hv = hex_digit(b);
    if (eoi) begin
      case (rmode)
        ST_AMP:         emit(AMP_CH);
        ST_HASH: begin
          emit(AMP_CH);
          emit(HASH_CH);
        end
        ST_HEXSTART:    replay_hex_start();
        ST_DEC, ST_HEX: encode_cp();
        ST_NAME:        if (!lookup_name()) replay_name();
        default: ;
      endcase
      clear_ref();
    end else begin
      case (rmode)
        ST_AMP: begin
          if (b == HASH_CH) begin
            rmode = ST_HASH;
          end else if (is_alnum(b)) begin
            nbuf[0] = b;
            nlen = 1;
            rmode = ST_NAME;
          end else begin
            emit(AMP_CH);
            as_text(b);
          end
        end
        ST_HASH: begin
          if (is_dec(b)) begin
            cp = 21'(hv);
            rmode = ST_DEC;
          end else if (b == LOWER_X_CH || b == UPPER_X_CH) begin
            hex_upper = (b == UPPER_X_CH);
            rmode = ST_HEXSTART;
          end else begin
            emit(AMP_CH);
            emit(HASH_CH);
            as_text(b);
          end
        end
        ST_HEXSTART: begin
          if (hv >= 0) begin
            cp = 21'(hv);
            rmode = ST_HEX;
          end else begin
            replay_hex_start();
            as_text(b);
          end
        end
        ST_DEC, ST_HEX: begin
          if ((rmode == ST_DEC) ? is_dec(b) : (hv >= 0)) begin
            acc = cp * ((rmode == ST_DEC) ? 10 : 16) + hv;
            cp = (acc > CP_TOP) ? CP_SATURATED : acc[20:0];
          end else begin
            encode_cp();
            clear_ref();
            if (b != SEMI_CH) as_text(b);
          end
        end
        ST_NAME: begin
          if (is_alnum(b)) begin
            if (nlen < NAME_MAX) begin
              nbuf[nlen] = b;
              nlen++;
            end else begin
              replay_name();
              as_text(b);
            end
          end else if (lookup_name()) begin
            clear_ref();
            if (b != SEMI_CH) as_text(b);
          end else begin
            replay_name();
            as_text(b);
          end
        end
        default: as_text(b);
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  // Random wait before each offer or pop, with occasional stretches of no waiting.
  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 31) == 0) calm[side] = !calm[side];
    return calm[side] ? 0 : int'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] random_alnum();
    return ALNUM.getc($urandom_range(0, ALNUM.len() - 1));
  endfunction

  function automatic int unsigned pick_code_point();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(1, 'h7F);
      2: return $urandom_range('h80, 'h7FF);
      3: return $urandom_range('h800, 'hFFFF);
      4: return $urandom_range('h10000, 'h10FFFF);
      5: return $urandom_range('h110000, 'hFFFFFFF);
      6: return CP_CORNERS[$urandom_range(0, 7)];
      default: return $urandom_range(1, 'h10FFFF);
    endcase
  endfunction

  // Offers one word, waits for it to be taken and books its expected bytes.
  task automatic send_word(input logic [7:0] b, input logic eoi, input int n_typed,
                           input logic [63:0] typed);
    int        gap;
    out_word_t w;
    gap = draw_gap(SIDE_IN);
    @(negedge clk);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
    if (eoi) ends_sent++;
    decode_word(b, eoi);
    // A typed row overrides the prediction; the state still advances.
    if (n_typed != PREDICT) begin
      step_bytes.delete();
      for (int i = 0; i < n_typed; i++) step_bytes = {step_bytes, typed[63 - 8*i -: 8]};
    end
    if (step_bytes.size() > longest_step) longest_step = step_bytes.size();
    for (int i = 0; i < step_bytes.size(); i++) begin
      w.ch = step_bytes[i];
      w.last = (i == step_bytes.size() - 1);
      utf8_expected = {utf8_expected, w};
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s.getc(i), 1'b0, PREDICT, '0);
  endtask

  task automatic end_reference();
    case ($urandom_range(0, 5))
      0, 1: send_word(SEMI_CH, 1'b0, PREDICT, '0);
      2:    send_word(8'($urandom_range(0, 255)), 1'b1, PREDICT, '0);
      3:    send_word(8'($urandom_range(0, 255)), 1'b0, PREDICT, '0);
      4:    send_word(AMP_CH, 1'b0, PREDICT, '0);
      default: ;
    endcase
  endtask

  task automatic random_chunk();
    int          pick;
    int          j;
    int unsigned v;
    string       nm;
    string       digits;
    string       prefix;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      n_plain++;
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0, PREDICT, '0);
    end else if (pick < 45) begin
      n_named++;
      nm = ent_name[$urandom_range(0, ENT_COUNT - 1)];
      case ($urandom_range(0, 7))
        0: begin
          j = $urandom_range(0, nm.len() - 1);
          c = nm.getc(j);
          if (c >= "a" && c <= "z") nm.putc(j, c - 8'd32);
          else if (c >= "A" && c <= "Z") nm.putc(j, c + 8'd32);
        end
        1: nm = nm.substr(0, nm.len() - 2);
        2: nm = {nm, "q"};
        default: ;
      endcase
      send_text({"&", nm});
      end_reference();
    end else if (pick < 75) begin
      n_numeric++;
      v = pick_code_point();
      if ($urandom_range(0, 1)) begin
        digits = $sformatf("%0d", v);
        prefix = "&#";
      end else begin
        digits = $sformatf("%0h", v);
        for (int i = 0; i < digits.len(); i++) begin
          c = digits.getc(i);
          if (c >= "a" && $urandom_range(0, 1)) digits.putc(i, c - 8'd32);
        end
        prefix = $urandom_range(0, 1) ? "&#X" : "&#x";
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) digits = {"0", digits};
      send_text({prefix, digits});
      end_reference();
    end else if (pick < 87) begin
      // Arbitrary names, often past the buffer length.
      n_free_name++;
      send_word(AMP_CH, 1'b0, PREDICT, '0);
      repeat ($urandom_range(1, 9)) send_word(random_alnum(), 1'b0, PREDICT, '0);
      end_reference();
    end else begin
      n_broken++;
      case ($urandom_range(0, 3))
        0: send_text("&");
        1: send_text("&#");
        2: send_text("&#x");
        default: send_text("&#X");
      endcase
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, PREDICT, '0);
    end
  endtask

  // ---------------------------------------------------------------- result side

  initial begin : result_sink
    int gap;
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(SIDE_OUT);
      @(negedge clk);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      bytes_seen++;
      if (utf8_expected.size() == 0) begin
        errors++;
        $display("%0t ns: byte expected none, actual %h (last %b)", $time, out_byte,
                 out_last);
      end else begin
        oldest = utf8_expected.pop_front();
        if (out_byte !== oldest.ch) begin
          errors++;
          $display("%0t ns: out_byte expected %h, actual %h", $time, oldest.ch, out_byte);
        end
        if (out_last !== oldest.last) begin
          errors++;
          $display("%0t ns: out_last expected %b, actual %b", $time, oldest.last,
                   out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still outstanding", cycle_count,
               utf8_expected.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_byte = 8'h00;
    in_end_of_input = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) send_word(script[r].b, script[r].eoi, script[r].n, script[r].bytes);
    while (words_sent < $size(script) + RANDOM_WORDS) random_chunk();

    @(negedge clk);
    in_push <= 1'b0;
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d end markers), checked %0d output bytes, longest %0d",
             words_sent, ends_sent, bytes_seen, longest_step);
    $display("random mix: %0d plain, %0d named, %0d numeric, %0d free names, %0d cut short",
             n_plain, n_named, n_numeric, n_free_name, n_broken);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
